>>> design/acms_pkg.sv
// types, codes and constants shared by the alpha coverage mip scaler
package acms_pkg;

  localparam int COUNT_W    = 19;
  localparam int SCALE_W    = 25;
  localparam int CUTOFF_W   = 17;
  localparam int ALPHA_W    = 8;
  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = 8;
  localparam int THR_W      = 27;
  localparam int ACC_W      = 33;
  localparam int COVER_W    = 27;
  localparam int MUL_A_W    = 27;
  localparam int MUL_B_W    = 25;
  localparam int MUL_P_W    = 52;
  localparam int LHS_W      = 46;
  localparam int RHS_W      = 38;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 19'h7FFFF;
  localparam logic [SCALE_W-1:0]  SCALE_ONE  = 25'd262144;
  localparam logic [SCALE_W-1:0]  SCALE_CAP  = 25'd16777216;
  localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = 17'd65536;
  localparam logic [ACC_W-1:0]    ROUND_LIMIT = 33'd66846720;
  localparam logic [ACC_W-1:0]    ROUND_HALF  = 33'd131072;
  localparam logic [ALPHA_W-1:0]  ALPHA_MAX   = 8'd255;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ADJUST = 1'b1;
  localparam logic RK_ALPHA    = 1'b0;
  localparam logic RK_SCALE    = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ALPHA_W-1:0] alpha;
    logic               level_is_base;
    logic               last_of_level;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [ALPHA_W-1:0] adjusted_alpha;
    logic [SCALE_W-1:0] alpha_scale;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST_WR,
    ST_RHS,
    ST_SWEEP,
    ST_EVAL_MUL,
    ST_EVAL_CMP,
    ST_RESULT,
    ST_ADJ
  } state_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 19'd1;
  endfunction

endpackage

>>> design/acms_if.sv
// valid/ready channel interfaces for texel items and result items

interface acms_in_if;
  import acms_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acms_out_if;
  import acms_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/acms_ram.sv
// generic single write port ram with registered read
module acms_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/alpha_coverage_mip_scaler_top.sv
// top level: coverage counting, histogram, scale search and alpha adjust
//
// Alpha coverage preserving mip scaler. Base-level sample beats can be taken
// back to back and set the target coverage. A sample beat of a later level
// does a read-modify-write of its histogram bin in the 256-entry histogram
// ram. An adjust beat multiplies its alpha by the current scale and waits for
// the output register. The last sample of a non-base level starts the scale
// search: every coverage evaluation sweeps all 256 bins through the single
// histogram read port, then drains and does one shared multiply and one
// compare, and a search runs 1 to 6 doubling evaluations plus
// BISECTION_STEPS bisection evaluations. With a disabled cutoff or a zero
// target the level end skips the search and reports a scale of one.
// The histogram needs no clearing pass: per-bin valid flags are cleared
// together at reset and at each level end. Intake is stalled while the
// search runs.
module alpha_coverage_mip_scaler_top #(
  parameter int BISECTION_STEPS = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  acms_in_if.sink                       in_ch,
  acms_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [acms_pkg::CUTOFF_W-1:0] cfg_wdata
);
  import acms_pkg::*;

  localparam int STEP_W = $clog2(BISECTION_STEPS + 1);

  state_t state_r, state_nxt;

  logic [CUTOFF_W-1:0]   cutoff_r;
  logic [COUNT_W-1:0]    base_covered_r, base_total_r, level_total_r;
  logic                  base_done_r;
  logic [SCALE_W-1:0]    cur_scale_r;
  logic [HIST_DEPTH-1:0] hist_valid_r;

  logic [ALPHA_W-1:0] alpha_r;
  logic               last_r;

  logic [SCALE_W-1:0] high_r, low_r, eval_s_r;
  logic               bisect_r;
  logic [STEP_W-1:0]  step_r;
  logic [8:0]         bin_r;
  logic [ACC_W-1:0]   acc_r;
  logic               pv_r, pp_r, ph_r;
  logic [COVER_W-1:0] covered_r;
  logic [MUL_P_W-1:0] mul_r;
  logic [RHS_W-1:0]   rhs_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // combinational controls
  logic               in_ready;
  logic               in_acc;
  logic               out_free;
  logic               enabled;
  logic [THR_W-1:0]   thr;
  logic               base_pass;
  logic [HIST_AW-1:0] ram_raddr;
  logic               ram_we;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] ram_rdata;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               sweep_start;

  // search decision
  logic               below;
  logic [SCALE_W-1:0] dbl;
  logic [SCALE_W-1:0] cmp_high, cmp_low, next_eval;
  logic               go_bisect, search_done;
  logic [SCALE_W:0]   mid_sum;

  logic [ACC_W-1:0]   adj_p;
  logic [ACC_W-1:0]   adj_round;
  logic [ALPHA_W-1:0] adj_alpha;

  assign in_acc   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign enabled  = (cutoff_r != '0) && (cutoff_r <= CUTOFF_MAX);
  // 1020 * cutoff
  assign thr       = (THR_W'(cutoff_r) << 10) - (THR_W'(cutoff_r) << 2);
  assign base_pass = enabled && (THR_W'({in_ch.data.alpha, 18'd0}) >= thr);
  assign mul_p     = {{(MUL_P_W-MUL_A_W){1'b0}}, mul_a} * {{(MUL_P_W-MUL_B_W){1'b0}}, mul_b};

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  acms_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (alpha_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.kind == KIND_ADJUST) begin
            state_nxt = ST_ADJ;
          end else if (!in_ch.data.level_is_base) begin
            state_nxt = ST_HIST_WR;
          end
        end
      end
      ST_HIST_WR: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (!enabled || base_covered_r == '0) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_RHS;
        end
      end
      ST_RHS:      state_nxt = ST_SWEEP;
      ST_SWEEP:    if (bin_r[8]) state_nxt = ST_EVAL_MUL;
      ST_EVAL_MUL: state_nxt = ST_EVAL_CMP;
      ST_EVAL_CMP: state_nxt = search_done ? ST_RESULT : ST_SWEEP;
      ST_RESULT:   if (out_free) state_nxt = ST_IDLE;
      ST_ADJ:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    ram_raddr   = in_ch.data.alpha;
    ram_we      = 1'b0;
    ram_wdata   = sat_inc(hist_valid_r[alpha_r] ? ram_rdata : '0);
    mul_a       = MUL_A_W'(in_ch.data.alpha);
    mul_b       = cur_scale_r;
    sweep_start = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_HIST_WR: ram_we = 1'b1;
      ST_RHS: begin
        mul_a       = MUL_A_W'(base_covered_r);
        mul_b       = MUL_B_W'(level_total_r);
        sweep_start = 1'b1;
      end
      ST_SWEEP:   ram_raddr = bin_r[HIST_AW-1:0];
      ST_EVAL_MUL: begin
        mul_a = covered_r;
        mul_b = MUL_B_W'(base_total_r);
      end
      ST_EVAL_CMP: sweep_start = !search_done;
      ST_RESULT, ST_ADJ: ;
      default: ;
    endcase
  end

  // doubling then bisection
  always_comb begin
    below     = mul_r[LHS_W-1:0] < LHS_W'(rhs_r);
    dbl       = high_r << 1;
    go_bisect = 1'b0;
    cmp_low   = low_r;
    cmp_high  = high_r;
    if (!bisect_r) begin
      if (below && dbl != SCALE_CAP) begin
        cmp_high = dbl;
      end else begin
        cmp_high  = below ? dbl : high_r;
        go_bisect = 1'b1;
      end
      search_done = 1'b0;
    end else begin
      cmp_low     = below ? eval_s_r : low_r;
      cmp_high    = below ? high_r : eval_s_r;
      search_done = (step_r + STEP_W'(1)) == STEP_W'(BISECTION_STEPS);
    end
    mid_sum = {1'b0, cmp_low} + {1'b0, cmp_high};
    if (!bisect_r && !go_bisect) begin
      next_eval = cmp_high;
    end else begin
      next_eval = mid_sum[SCALE_W:1];
    end
  end

  // adjust rounding from the registered product
  always_comb begin
    adj_p     = mul_r[ACC_W-1:0];
    adj_round = adj_p + ROUND_HALF;
    if (adj_p >= ROUND_LIMIT) begin
      adj_alpha = ALPHA_MAX;
    end else begin
      adj_alpha = adj_round[25:18];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cutoff_r       <= '0;
      base_covered_r <= '0;
      base_total_r   <= '0;
      level_total_r  <= '0;
      base_done_r    <= 1'b0;
      cur_scale_r    <= SCALE_ONE;
      hist_valid_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
      if ((state_r == ST_RESULT || state_r == ST_ADJ) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_ch.data.kind == KIND_SAMPLE) begin
        if (in_ch.data.level_is_base) begin
          // first beat after a finished base level starts a new target
          base_total_r <= sat_inc(base_done_r ? '0 : base_total_r);
          if (base_pass) begin
            base_covered_r <= sat_inc(base_done_r ? '0 : base_covered_r);
          end else if (base_done_r) begin
            base_covered_r <= '0;
          end
          base_done_r <= in_ch.data.last_of_level;
        end else begin
          level_total_r <= sat_inc(level_total_r);
        end
      end
      if (state_r == ST_HIST_WR) begin
        hist_valid_r[alpha_r] <= 1'b1;
      end
      if (state_r == ST_RESULT && out_free) begin
        cur_scale_r   <= high_r;
        hist_valid_r  <= '0;
        level_total_r <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      alpha_r <= in_ch.data.alpha;
      last_r  <= in_ch.data.last_of_level;
      mul_r   <= mul_p;
    end
    if (state_r == ST_HIST_WR) begin
      high_r <= SCALE_ONE;
    end
    if (state_r == ST_RHS) begin
      rhs_r    <= mul_p[RHS_W-1:0];
      high_r   <= SCALE_ONE;
      low_r    <= '0;
      eval_s_r <= SCALE_ONE;
      bisect_r <= 1'b0;
      step_r   <= '0;
    end
    if (sweep_start) begin
      bin_r     <= '0;
      acc_r     <= '0;
      covered_r <= '0;
      pv_r      <= 1'b0;
    end
    if (state_r == ST_SWEEP) begin
      // acc_r holds bin * scale for the bin being issued
      if (!bin_r[8]) begin
        bin_r <= bin_r + 9'd1;
        acc_r <= acc_r + ACC_W'(eval_s_r);
        pp_r  <= acc_r >= ACC_W'(thr);
        ph_r  <= hist_valid_r[bin_r[HIST_AW-1:0]];
        pv_r  <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
      if (pv_r && pp_r && ph_r) begin
        covered_r <= covered_r + COVER_W'(ram_rdata);
      end
    end
    if (state_r == ST_EVAL_MUL) begin
      mul_r <= mul_p;
    end
    if (state_r == ST_EVAL_CMP) begin
      high_r   <= cmp_high;
      low_r    <= cmp_low;
      eval_s_r <= next_eval;
      if (go_bisect) begin
        bisect_r <= 1'b1;
      end
      if (bisect_r) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
    if (state_r == ST_RESULT && out_free) begin
      out_data_r.result_kind    <= RK_SCALE;
      out_data_r.adjusted_alpha <= '0;
      out_data_r.alpha_scale    <= high_r;
    end
    if (state_r == ST_ADJ && out_free) begin
      out_data_r.result_kind    <= RK_ALPHA;
      out_data_r.adjusted_alpha <= adj_alpha;
      out_data_r.alpha_scale    <= '0;
    end
  end

endmodule

>>> bench/acms_checker.sv
`timescale 1ns / 100ps
// checker: tracks the scaler state from observed beats and compares every result beat
module acms_checker
  import acms_pkg::*;
#(
  parameter int SEARCH_STEPS = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  acms_in_if                  in_mon,
  acms_out_if                 out_mon,
  input  logic                cfg_we,
  input  logic [CUTOFF_W-1:0] cfg_wdata,
  input  logic                drain_done,
  output int                  fail_count,
  output int                  owed_count,
  output int                  texel_count,
  output int                  adjust_count,
  output int                  scale_count
);

  logic [COUNT_W-1:0]  bin_count [HIST_DEPTH];
  logic [COUNT_W-1:0]  base_hits;
  logic [COUNT_W-1:0]  base_texels;
  logic [COUNT_W-1:0]  level_texels;
  logic [SCALE_W-1:0]  held_scale;
  logic                base_closed;
  logic [CUTOFF_W-1:0] cutoff;
  out_item_t           owed_results[$];
  out_item_t           unsent;
  bit                  leftovers_flagged;

  initial begin
    fail_count   = 0;
    owed_count   = 0;
    texel_count  = 0;
    adjust_count = 0;
    scale_count  = 0;
    leftovers_flagged = 1'b0;
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (fail_count < 40) begin
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  function automatic bit cutoff_live();
    return cutoff != '0 && cutoff <= CUTOFF_MAX;
  endfunction

  // alpha/255 * scale reaches the cutoff, cross-multiplied
  function automatic bit texel_passes(input logic [ALPHA_W-1:0] a,
                                      input logic [SCALE_W-1:0] s);
    return 64'(a) * 64'(s) >= 64'd1020 * 64'(cutoff);
  endfunction

  function automatic bit short_of_target(input logic [SCALE_W-1:0] s);
    longint unsigned hit;
    hit = 0;
    for (int a = 0; a < HIST_DEPTH; a++) begin
      if (texel_passes(8'(a), s)) hit += bin_count[a];
    end
    return hit * 64'(base_texels) < 64'(base_hits) * 64'(level_texels);
  endfunction

  function automatic logic [SCALE_W-1:0] search_scale();
    logic [SCALE_W:0] lo;
    logic [SCALE_W:0] hi;
    logic [SCALE_W:0] mid;
    if (!cutoff_live() || base_hits == '0) return SCALE_ONE;
    lo = '0;
    hi = 26'(SCALE_ONE);
    while (hi < 26'(SCALE_CAP) && short_of_target(hi[SCALE_W-1:0])) hi = hi << 1;
    for (int i = 0; i < SEARCH_STEPS; i++) begin
      mid = (lo + hi) >> 1;
      if (short_of_target(mid[SCALE_W-1:0])) lo = mid;
      else hi = mid;
    end
    return hi[SCALE_W-1:0];
  endfunction

  task automatic scale_texel(input in_item_t it);
    out_item_t res;
    longint unsigned prod;
    res = '0;
    if (it.kind == KIND_ADJUST) begin
      prod = 64'(it.alpha) * 64'(held_scale);
      res.result_kind    = RK_ALPHA;
      res.adjusted_alpha = (prod >= 64'(ROUND_LIMIT)) ? ALPHA_MAX
                                                      : 8'((prod + 64'(ROUND_HALF)) >> 18);
      owed_results.insert(owed_results.size(), res);
      adjust_count++;
    end else if (it.level_is_base) begin
      // a new base level after a closed one starts a fresh target
      if (base_closed) begin
        base_hits   = '0;
        base_texels = '0;
        base_closed = 1'b0;
      end
      base_texels = count_up(base_texels);
      if (cutoff_live() && texel_passes(it.alpha, SCALE_ONE)) base_hits = count_up(base_hits);
      if (it.last_of_level) base_closed = 1'b1;
      texel_count++;
    end else begin
      bin_count[it.alpha] = count_up(bin_count[it.alpha]);
      level_texels = count_up(level_texels);
      texel_count++;
      if (it.last_of_level) begin
        held_scale = search_scale();
        foreach (bin_count[i]) bin_count[i] = '0;
        level_texels = '0;
        res.result_kind = RK_SCALE;
        res.alpha_scale = held_scale;
        owed_results.insert(owed_results.size(), res);
        scale_count++;
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (owed_results.size() == 0) begin
      flag_mismatch("unexpected result beat, scale", got.alpha_scale, 0);
      return;
    end
    want = owed_results.pop_front();
    if (got.result_kind !== want.result_kind) begin
      flag_mismatch("result_kind", got.result_kind, want.result_kind);
    end
    if (got.adjusted_alpha !== want.adjusted_alpha) begin
      flag_mismatch("adjusted_alpha", got.adjusted_alpha, want.adjusted_alpha);
    end
    if (got.alpha_scale !== want.alpha_scale) begin
      flag_mismatch("alpha_scale", got.alpha_scale, want.alpha_scale);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bin_count[i]) bin_count[i] = '0;
      base_hits    = '0;
      base_texels  = '0;
      level_texels = '0;
      held_scale   = SCALE_ONE;
      base_closed  = 1'b0;
      cutoff       = '0;
      owed_results.delete();
    end else begin
      if (cfg_we) cutoff = cfg_wdata;
      // results first: a beat leaving now never stems from a beat entering now
      if (out_mon.valid && out_mon.ready) check_result(out_mon.data);
      if (in_mon.valid && in_mon.ready) scale_texel(in_mon.data);
      if (drain_done && !leftovers_flagged) begin
        leftovers_flagged = 1'b1;
        while (owed_results.size() != 0) begin
          unsent = owed_results.pop_front();
          flag_mismatch("result never delivered, scale", 0, unsent.alpha_scale);
        end
      end
    end
    owed_count = owed_results.size();
  end

endmodule

>>> bench/tb_alpha_coverage_mip_scaler_top.sv
`timescale 1ns / 100ps
// testbench top: drives texel beats and cutoff writes, stalls results, gives the verdict
module tb_alpha_coverage_mip_scaler_top;
  import acms_pkg::*;

  localparam int STEPS        = 18;
  localparam int FLOOD_TEXELS = 64;
  localparam int FLOOD_MISSES = 16;
  localparam int PHASE_ITEMS  = 100;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FIFTH, RX_TRICKLE} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CUTOFF_W-1:0] cfg_wdata;
  logic                drain_done;

  int fail_count, owed_count, texel_count, adjust_count, scale_count;
  int burst_left;
  int sent_items;
  int settings_seen;
  bit steady;
  rx_mode_t rx_mode;
  int rx_left;
  int rx_tick;

  acms_in_if  texel_ch ();
  acms_out_if result_ch ();

  alpha_coverage_mip_scaler_top #(.BISECTION_STEPS(STEPS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (texel_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  acms_checker #(.SEARCH_STEPS(STEPS)) chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (texel_ch),
    .out_mon      (result_ch),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .drain_done   (drain_done),
    .fail_count   (fail_count),
    .owed_count   (owed_count),
    .texel_count  (texel_count),
    .adjust_count (adjust_count),
    .scale_count  (scale_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls follow a randomly chosen mode that is redrawn when its countdown runs out
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 240);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:        result_ch.ready <= 1'b1;
      RX_COIN:        result_ch.ready <= 1'($urandom_range(0, 1));
      RX_EVERY_FIFTH: result_ch.ready <= (rx_tick % 5) == 0;
      default:        result_ch.ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic push_texel(input logic kind, input logic [ALPHA_W-1:0] alpha,
                            input logic is_base, input logic last);
    in_item_t it;
    it.kind          = kind;
    it.alpha         = alpha;
    it.level_is_base = is_base;
    it.last_of_level = last;
    if (!steady && burst_left <= 0) begin
      texel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    texel_ch.valid <= 1'b1;
    texel_ch.data  <= it;
    do @(posedge clk); while (texel_ch.ready !== 1'b1);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic push_any_adjust();
    push_texel(KIND_ADJUST, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  task automatic send_run(input logic is_base, input int n, input int cap, input bit closed);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) push_any_adjust();
      push_texel(KIND_SAMPLE, 8'($urandom_range(0, cap)), is_base, closed && (i == n - 1));
    end
  endtask

  task automatic settle();
    texel_ch.valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    // a beat with no result may still be in flight
    repeat (16) @(negedge clk);
  endtask

  task automatic write_cutoff(input logic [CUTOFF_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_seen++;
  endtask

  task automatic run_phase(input int budget);
    int start;
    int pick;
    int base_cap;
    start = sent_items;
    while (sent_items - start < budget) begin
      pick = $urandom_range(0, 9);
      base_cap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 255;
      case (pick)
        0, 1, 2, 3, 4, 5: begin
          // well-formed chain: base level, then one to three later levels
          send_run(1'b1, $urandom_range(1, 40), base_cap, 1'b1);
          repeat ($urandom_range(1, 3)) begin
            send_run(1'b0, $urandom_range(1, 12), $urandom_range(0, 255), 1'b1);
            repeat ($urandom_range(0, 4)) push_any_adjust();
          end
        end
        6: begin
          repeat ($urandom_range(4, 16)) begin
            push_texel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
          end
        end
        7: begin
          // base level left open, so the next base beats keep adding to it
          send_run(1'b1, $urandom_range(1, 20), base_cap, 1'b0);
          send_run(1'b0, $urandom_range(1, 12), $urandom_range(0, 255), 1'b1);
        end
        8: send_run(1'b0, $urandom_range(1, 12), $urandom_range(0, 255), 1'b1);
        default: repeat ($urandom_range(4, 20)) push_any_adjust();
      endcase
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    drain_done      = 1'b0;
    texel_ch.valid  = 1'b0;
    texel_ch.data   = '0;
    result_ch.ready = 1'b0;
    burst_left      = 0;
    sent_items      = 0;
    settings_seen   = 0;
    steady          = 1'b0;
    rx_left         = 0;
    rx_tick         = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // adjust ignores the level flags; no base texels means scale 1.0
    write_cutoff(17'd0);
    push_texel(KIND_ADJUST, 8'd0, 1'b1, 1'b1);
    push_texel(KIND_ADJUST, 8'd255, 1'b0, 1'b0);
    push_texel(KIND_SAMPLE, 8'd0, 1'b0, 1'b0);
    push_texel(KIND_SAMPLE, 8'd255, 1'b0, 1'b1);

    // half coverage at cutoff 0.5, then a dim level that needs scaling up
    write_cutoff(17'd32768);
    push_texel(KIND_SAMPLE, 8'd255, 1'b1, 1'b0);
    push_texel(KIND_SAMPLE, 8'd0, 1'b1, 1'b0);
    push_texel(KIND_SAMPLE, 8'd128, 1'b1, 1'b0);
    push_texel(KIND_SAMPLE, 8'd127, 1'b1, 1'b1);
    push_texel(KIND_ADJUST, 8'd200, 1'b0, 1'b0);
    push_texel(KIND_SAMPLE, 8'd60, 1'b0, 1'b0);
    push_texel(KIND_SAMPLE, 8'd70, 1'b0, 1'b1);
    push_texel(KIND_ADJUST, 8'd255, 1'b0, 1'b0);
    push_texel(KIND_ADJUST, 8'd128, 1'b0, 1'b0);
    push_texel(KIND_ADJUST, 8'd1, 1'b0, 1'b0);

    // fresh base level where nothing passes: zero target
    push_texel(KIND_SAMPLE, 8'd10, 1'b1, 1'b0);
    push_texel(KIND_SAMPLE, 8'd20, 1'b1, 1'b1);
    push_texel(KIND_SAMPLE, 8'd200, 1'b0, 1'b1);
    push_texel(KIND_ADJUST, 8'd200, 1'b0, 1'b0);

    // a base level sent back to back at full rate
    settle();
    steady = 1'b1;
    for (int i = 0; i < FLOOD_TEXELS; i++) begin
      push_texel(KIND_SAMPLE, (i < FLOOD_MISSES) ? 8'($urandom_range(0, 127))
                                                 : 8'($urandom_range(128, 255)),
                 1'b1, i == FLOOD_TEXELS - 1);
    end
    steady = 1'b0;
    send_run(1'b0, 8, 255, 1'b1);
    push_any_adjust();

    write_cutoff(17'd65536);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd1);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd32768);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd65537);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'($urandom_range(1, 65535)));
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd131071);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd0);
    run_phase(PHASE_ITEMS);
    write_cutoff(17'd49152);
    run_phase(PHASE_ITEMS);

    settle();
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);
    $display("checked %0d sample beats, %0d adjusted alphas and %0d level scales",
             texel_count, adjust_count, scale_count);
    $display("across %0d cutoff writes, including a back to back base level",
             settings_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results still owed", owed_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/acms_pkg.sv
design/acms_if.sv
design/acms_ram.sv
design/alpha_coverage_mip_scaler_top.sv
bench/acms_checker.sv
bench/tb_alpha_coverage_mip_scaler_top.sv
